>>> sv/set_assoc_cache_srrip_unit_defines.svh
// Assertion macros used by the checker file of the cache tag unit.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SET_ASSOC_CACHE_SRRIP_UNIT_DEFINES_SVH
`define SET_ASSOC_CACHE_SRRIP_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define SACS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define SACS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/sacs_pkg.sv
`default_nettype none

package sacs_pkg;

  // Fixed field widths of the channels
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned WAY_NUM_W   = 4;
  localparam int unsigned MAX_SET_W   = 16;
  localparam int unsigned MAX_TAG_W   = 32;

  // RRPV codes
  localparam logic [1:0] RRPV_HIT    = 2'd0;
  localparam logic [1:0] RRPV_INSERT = 2'd2;
  localparam logic [1:0] RRPV_MAX    = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              is_store;
  } sacs_in_t;

  typedef struct packed {
    logic                 hit;
    logic [WAY_NUM_W-1:0] way_used;
    logic                 replaced;
    logic                 dirty_eviction;
    logic [CNT_W-1:0]     load_hit_count;
    logic [CNT_W-1:0]     load_miss_count;
    logic [CNT_W-1:0]     store_hit_count;
    logic [CNT_W-1:0]     store_miss_count;
    logic [CNT_W-1:0]     dirty_eviction_count;
  } sacs_out_t;

  // Classified access, as queued between front and back
  typedef struct packed {
    logic [MAX_TAG_W-1:0] tag;
    logic [MAX_SET_W-1:0] set_idx;
    logic                 is_store;
  } sacs_req_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_READ,
    BK_EVAL
  } sacs_bk_state_t;

endpackage

`default_nettype wire

>>> sv/sacs_ram.sv
`default_nettype none

module sacs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> sv/sacs_fifo.sv
`default_nettype none

module sacs_fifo
  import sacs_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire sacs_req_t push_data,
  output logic           full,
  input  wire logic      pop,
  output sacs_req_t      head,
  output logic           empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W_Q = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]   LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W_Q-1:0] FULL_CNT = CNT_W_Q'(DEPTH);

  sacs_req_t            slot_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W_Q-1:0]   count_r, count_nxt;

  assign full  = (count_r == FULL_CNT);
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> sv/sacs_front.sv
`default_nettype none

module sacs_front
  import sacs_pkg::*;
#(
  parameter int unsigned ADDR_BITS = 32,
  parameter int unsigned OFF_BITS  = 6,
  parameter int unsigned SET_BITS  = 8
) (
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire sacs_in_t in_data,
  input  wire logic     busy,
  input  wire logic     q_full,
  output logic          q_push,
  output sacs_req_t     q_data
);

  localparam logic [ADDR_W:0] ADDR_MASK = (33'd1 << ADDR_BITS) - 33'd1;

  logic [ADDR_W-1:0]   addr_m;
  logic [ADDR_W-1:0]   line_addr;
  logic [SET_BITS-1:0] set_idx;

  // Split the address into set index and tag
  always_comb begin
    addr_m    = in_data.address & ADDR_MASK[ADDR_W-1:0];
    line_addr = addr_m >> OFF_BITS;
    set_idx   = line_addr[SET_BITS-1:0];
    q_data.tag      = MAX_TAG_W'(addr_m >> (OFF_BITS + SET_BITS));
    q_data.set_idx  = MAX_SET_W'(set_idx);
    q_data.is_store = in_data.is_store;
  end

  // Hold off while the queue is full or the tag store is being cleared
  assign in_stall = q_full | busy;
  assign q_push   = in_valid & ~in_stall;

endmodule

`default_nettype wire

>>> sv/sacs_back.sv
`default_nettype none

module sacs_back
  import sacs_pkg::*;
#(
  parameter int unsigned WAYS     = 8,
  parameter int unsigned SET_BITS = 8,
  parameter int unsigned TAG_W    = 18
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      q_empty,
  output logic           q_pop,
  input  wire sacs_req_t q_head,
  output logic           busy,
  output logic           out_valid,
  input  wire logic      out_stall,
  output sacs_out_t      out_data
);

  localparam int unsigned LINE_W = TAG_W + 4;
  localparam int unsigned ROW_W  = WAYS * LINE_W;
  localparam int unsigned SETS_N = 1 << SET_BITS;
  localparam logic [SET_BITS-1:0] LAST_SET = SET_BITS'(SETS_N - 1);

  sacs_bk_state_t      state_r, state_nxt;
  logic [SET_BITS-1:0] clr_idx_r, clr_idx_nxt;
  sacs_req_t           req_r;
  logic                out_valid_r, out_valid_nxt;
  sacs_out_t           out_data_r;
  logic [CNT_W-1:0]    lh_r, lm_r, sh_r, sm_r, de_r;
  logic [CNT_W-1:0]    lh_nxt, lm_nxt, sh_nxt, sm_nxt, de_nxt;

  logic                ram_we, ram_re;
  logic [SET_BITS-1:0] ram_waddr, ram_raddr;
  logic [ROW_W-1:0]    ram_wdata, rd_row, new_row;
  logic                out_free, eval_go;

  // Per-way view of the set row
  logic [WAYS-1:0]     way_v, way_d, match, first_oh, victim_oh;
  logic [1:0]          way_rr [WAYS];
  logic [TAG_W-1:0]    way_tag [WAYS];
  logic [TAG_W-1:0]    req_tag;
  logic                any_match, set_full, hit, fill_empty, dirty_ev;
  logic                any3, any2, any1, seen;
  logic [1:0]          top, age;
  logic [WAY_NUM_W-1:0] first_enc, victim_enc;
  sacs_out_t           result;

  sacs_ram #(
    .WIDTH(ROW_W),
    .DEPTH(SETS_N)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_row)
  );

  assign out_free = ~out_valid_r | ~out_stall;
  assign req_tag  = req_r.tag[TAG_W-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_CLEAR: if (clr_idx_r == LAST_SET) state_nxt = BK_READ;
      BK_READ:  if (!q_empty)              state_nxt = BK_EVAL;
      BK_EVAL:  if (out_free)              state_nxt = BK_READ;
      default:                             state_nxt = BK_CLEAR;
    endcase
  end

  // State outputs: memory port, queue pop, result strobe
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = req_r.set_idx[SET_BITS-1:0];
    ram_wdata = new_row;
    ram_re    = 1'b0;
    ram_raddr = q_head.set_idx[SET_BITS-1:0];
    q_pop     = 1'b0;
    eval_go   = 1'b0;
    busy      = 1'b0;
    unique case (state_r)
      BK_CLEAR: begin
        busy      = 1'b1;
        ram_we    = 1'b1;
        ram_waddr = clr_idx_r;
        ram_wdata = '0;
      end
      BK_READ: begin
        q_pop  = ~q_empty;
        ram_re = ~q_empty;
      end
      BK_EVAL: begin
        eval_go = out_free;
        ram_we  = out_free;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Unpack the row and find the first empty or matching way
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      way_v[w]   = rd_row[w*LINE_W];
      way_d[w]   = rd_row[w*LINE_W + 1];
      way_rr[w]  = rd_row[w*LINE_W + 2 +: 2];
      way_tag[w] = rd_row[w*LINE_W + 4 +: TAG_W];
      match[w]   = ~way_v[w] | (way_tag[w] == req_tag);
    end
    first_oh  = '0;
    first_enc = '0;
    seen      = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (match[w] && !seen) begin
        first_oh[w] = 1'b1;
        first_enc   = WAY_NUM_W'(w);
        seen        = 1'b1;
      end
    end
    any_match  = |match;
    set_full   = ~any_match;
    hit        = |(first_oh & way_v);
    fill_empty = any_match & ~hit;
  end

  // Age the full set and pick the lowest way at the top RRPV
  always_comb begin
    any3 = 1'b0;
    any2 = 1'b0;
    any1 = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      any3 = any3 | (way_rr[w] == 2'd3);
      any2 = any2 | (way_rr[w] == 2'd2);
      any1 = any1 | (way_rr[w] == 2'd1);
    end
    top = any3 ? 2'd3 : (any2 ? 2'd2 : (any1 ? 2'd1 : 2'd0));
    age = RRPV_MAX - top;
    victim_oh  = '0;
    victim_enc = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (way_rr[w] == top) begin
        victim_oh  = '0;
        victim_oh[w] = 1'b1;
        victim_enc = WAY_NUM_W'(w);
      end
    end
    dirty_ev = set_full & |(victim_oh & way_d);
  end

  // Build the row to write back
  always_comb begin
    new_row = rd_row;
    for (int w = 0; w < WAYS; w++) begin
      if (hit && first_oh[w]) begin
        new_row[w*LINE_W + 1]      = way_d[w] | req_r.is_store;
        new_row[w*LINE_W + 2 +: 2] = RRPV_HIT;
      end
      if (set_full) begin
        new_row[w*LINE_W + 2 +: 2] = way_rr[w] + age;
      end
      if ((fill_empty && first_oh[w]) || (set_full && victim_oh[w])) begin
        new_row[w*LINE_W]              = 1'b1;
        new_row[w*LINE_W + 1]          = req_r.is_store;
        new_row[w*LINE_W + 2 +: 2]     = RRPV_INSERT;
        new_row[w*LINE_W + 4 +: TAG_W] = req_tag;
      end
    end
  end

  // Update the running totals
  always_comb begin
    lh_nxt = lh_r;
    lm_nxt = lm_r;
    sh_nxt = sh_r;
    sm_nxt = sm_r;
    de_nxt = de_r;
    if (eval_go) begin
      if (hit && req_r.is_store)   sh_nxt = sh_r + 1'b1;
      if (hit && !req_r.is_store)  lh_nxt = lh_r + 1'b1;
      if (!hit && req_r.is_store)  sm_nxt = sm_r + 1'b1;
      if (!hit && !req_r.is_store) lm_nxt = lm_r + 1'b1;
      if (dirty_ev)                de_nxt = de_r + 1'b1;
    end
  end

  // Assemble the result beat
  always_comb begin
    result.hit                  = hit;
    result.way_used             = set_full ? victim_enc : first_enc;
    result.replaced             = set_full;
    result.dirty_eviction       = dirty_ev;
    result.load_hit_count       = lh_nxt;
    result.load_miss_count      = lm_nxt;
    result.store_hit_count      = sh_nxt;
    result.store_miss_count     = sm_nxt;
    result.dirty_eviction_count = de_nxt;
  end

  // Load on a new result, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (eval_go) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    clr_idx_nxt = (state_r == BK_CLEAR) ? clr_idx_r + 1'b1 : clr_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      lh_r        <= '0;
      lm_r        <= '0;
      sh_r        <= '0;
      sm_r        <= '0;
      de_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
      lh_r        <= lh_nxt;
      lm_r        <= lm_nxt;
      sh_r        <= sh_nxt;
      sm_r        <= sm_nxt;
      de_r        <= de_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      req_r <= q_head;
    end
    if (eval_go) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> sv/set_assoc_cache_srrip_unit.sv
// Tag array of a WAYS-way set-associative cache with 2-bit SRRIP replacement.
// Each input beat is one load or store byte address; each yields exactly one
// result beat with hit, way, eviction flags and the five running totals taken
// after that access. The set row (valid, dirty, RRPV and tag of every way)
// lives in one synchronous memory, so an access first reads the row, then
// compares and ages all ways in parallel and writes the row back. A two-entry
// queue sits between the address decoder and the lookup engine, and the result
// register accepts a new beat while the previous one is being taken. After
// reset the unit clears the row memory one set a cycle, 2**floor(log2(SETS))
// sets (256 at the default size); in_stall stays high during that pass.
`default_nettype none

module set_assoc_cache_srrip_unit
  import sacs_pkg::*;
#(
  parameter int unsigned WAYS        = 8,
  parameter int unsigned SETS        = 256,
  parameter int unsigned BLOCK_BYTES = 64,
  parameter int unsigned ADDR_BITS   = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire sacs_in_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output sacs_out_t     out_data
);

  localparam int OFF_BITS = $clog2(BLOCK_BYTES + 1) - 1;
  localparam int SET_BITS = $clog2(SETS + 1) - 1;
  localparam int TAG_RAW  = ADDR_BITS - OFF_BITS - SET_BITS;
  localparam int TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;

  logic      busy, q_full, q_push, q_empty, q_pop;
  sacs_req_t q_data, q_head;

  sacs_front #(
    .ADDR_BITS (ADDR_BITS),
    .OFF_BITS  (OFF_BITS),
    .SET_BITS  (SET_BITS)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .busy     (busy),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  sacs_fifo #(
    .DEPTH (2)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  sacs_back #(
    .WAYS     (WAYS),
    .SET_BITS (SET_BITS),
    .TAG_W    (TAG_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_head    (q_head),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> sv/sacs_chk.sv
`default_nettype none
`include "set_assoc_cache_srrip_unit_defines.svh"

module sacs_chk
  import sacs_pkg::*;
#(
  parameter int unsigned WAYS = 8
) (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire sacs_out_t out_data
);

  logic held, hit_v, evict_any, dirty_v;

  // Qualify the result beat flags
  assign held      = out_valid & out_stall;
  assign hit_v     = out_valid & out_data.hit;
  assign evict_any = out_data.replaced | out_data.dirty_eviction;
  assign dirty_v   = out_valid & out_data.dirty_eviction;

  // A stalled result beat holds
  `SACS_ASSERT_NEXT(a_out_hold, held, out_valid && $stable(out_data), "stalled result changed")

  // The reported way exists
  `SACS_ASSERT_NOW(a_way_range, out_valid, 32'(out_data.way_used) < WAYS, "way out of range")

  // A hit never evicts
  `SACS_ASSERT_NOW(a_hit_no_evict, hit_v, !evict_any, "hit reported an eviction")

  // A dirty eviction is always a replacement
  `SACS_ASSERT_NOW(a_dirty_is_repl, dirty_v, out_data.replaced, "dirty eviction, no replacement")

endmodule

bind set_assoc_cache_srrip_unit sacs_chk #(
  .WAYS (WAYS)
) u_sacs_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

>>> test/set_assoc_cache_srrip_unit_tb.sv
module set_assoc_cache_srrip_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sacs_pkg::*;

  localparam int NUM_WAYS    = 8;
  localparam int NUM_SETS    = 256;
  localparam int BLOCK_SIZE  = 64;
  localparam int ADDR_SPAN   = 32;
  localparam int OFS_W       = 6;
  localparam int IDX_W       = 8;
  localparam int TAG_W       = ADDR_SPAN - OFS_W - IDX_W;
  localparam int NUM_LINES   = NUM_WAYS * NUM_SETS;
  localparam int PHASE_ITEMS = 440;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT_NS    = 2_000_000;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  sacs_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  sacs_out_t out_data;

  // Shadow tag array and running totals
  bit               tag_valid  [NUM_LINES];
  logic [TAG_W-1:0] tag_store  [NUM_LINES];
  bit               dirty_flag [NUM_LINES];
  logic [1:0]       rrpv_val   [NUM_LINES];
  logic [31:0]      load_hits_n, load_misses_n, store_hits_n, store_misses_n;
  logic [31:0]      dirty_evicts_n;
  int               evict_n;

  sacs_out_t expected_q [$];
  int        accepted_n = 0;
  int        checked_n  = 0;
  int        mismatch_n = 0;

  // Traffic shaping knobs, percent per cycle
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_req  = 0;
  int hold_left = 0;

  set_assoc_cache_srrip_unit #(
    .WAYS(NUM_WAYS),
    .SETS(NUM_SETS),
    .BLOCK_BYTES(BLOCK_SIZE),
    .ADDR_BITS(ADDR_SPAN)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d results outstanding", expected_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void clear_model();
    for (int i = 0; i < NUM_LINES; i++) begin
      tag_valid[i]  = 1'b0;
      tag_store[i]  = '0;
      dirty_flag[i] = 1'b0;
      rrpv_val[i]   = '0;
    end
    load_hits_n    = '0;
    load_misses_n  = '0;
    store_hits_n   = '0;
    store_misses_n = '0;
    dirty_evicts_n = '0;
    evict_n        = 0;
  endfunction

  function automatic logic [31:0] line_addr(input logic [TAG_W-1:0] tag,
                                            input logic [IDX_W-1:0] set_i,
                                            input logic [OFS_W-1:0] ofs);
    return {tag, set_i, ofs};
  endfunction

  // Look up one access in the shadow array, update it, return the result beat
  function automatic sacs_out_t predict_access(input logic [31:0] addr, input logic st);
    logic [IDX_W-1:0] set_i;
    logic [TAG_W-1:0] tag_i;
    logic [1:0]       top;
    logic [1:0]       age;
    int               base;
    int               way;
    bit               hit;
    bit               found;
    bit               picked;
    sacs_out_t        r;
    set_i  = addr[OFS_W +: IDX_W];
    tag_i  = addr[ADDR_SPAN-1 -: TAG_W];
    base   = int'(set_i) * NUM_WAYS;
    way    = 0;
    hit    = 1'b0;
    found  = 1'b0;
    picked = 1'b0;
    r      = '0;
    // search from way 0: first empty way or first tag match wins
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!hit && !found) begin
        if (!tag_valid[base+w]) begin
          way   = w;
          found = 1'b1;
        end else if (tag_store[base+w] == tag_i) begin
          way = w;
          hit = 1'b1;
        end
      end
    end
    if (hit) begin
      rrpv_val[base+way] = RRPV_HIT;
      if (st) begin
        dirty_flag[base+way] = 1'b1;
        store_hits_n++;
      end else begin
        load_hits_n++;
      end
    end else begin
      // full set: age everyone until some way is at the top, evict the lowest such
      if (!found) begin
        top = '0;
        for (int w = 0; w < NUM_WAYS; w++)
          if (rrpv_val[base+w] > top) top = rrpv_val[base+w];
        age = RRPV_MAX - top;
        for (int w = 0; w < NUM_WAYS; w++) rrpv_val[base+w] = rrpv_val[base+w] + age;
        way = 0;
        for (int w = 0; w < NUM_WAYS; w++) begin
          if (!picked && rrpv_val[base+w] == RRPV_MAX) begin
            way    = w;
            picked = 1'b1;
          end
        end
        r.replaced       = 1'b1;
        r.dirty_eviction = dirty_flag[base+way];
        evict_n++;
        if (dirty_flag[base+way]) dirty_evicts_n++;
      end
      tag_valid[base+way]  = 1'b1;
      tag_store[base+way]  = tag_i;
      rrpv_val[base+way]   = RRPV_INSERT;
      dirty_flag[base+way] = st;
      if (st) store_misses_n++;
      else load_misses_n++;
    end
    r.hit                  = hit;
    r.way_used             = WAY_NUM_W'(way);
    r.load_hit_count       = load_hits_n;
    r.load_miss_count      = load_misses_n;
    r.store_hit_count      = store_hits_n;
    r.store_miss_count     = store_misses_n;
    r.dirty_eviction_count = dirty_evicts_n;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_n++;
    if (mismatch_n <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v)
      flag_mismatch($sformatf("beat %0d %s: expected %0h, got %0h",
                              checked_n, name, exp_v, act_v));
  endtask

  // Offer one access beat, hold it until taken, then queue its expected result
  task automatic send_access(input logic [31:0] addr, input logic st);
    sacs_in_t beat;
    beat.address  = addr;
    beat.is_store = st;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    expected_q.push_back(predict_access(addr, st));
    accepted_n++;
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Result side: random stall, or a long hold when one is requested
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each taken result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    sacs_out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_q.size() == 0) begin
        flag_mismatch($sformatf("result beat with nothing expected: %h", out_data));
      end else begin
        want = expected_q.pop_front();
        check_field("hit", want.hit, out_data.hit);
        check_field("way_used", want.way_used, out_data.way_used);
        check_field("replaced", want.replaced, out_data.replaced);
        check_field("dirty_eviction", want.dirty_eviction, out_data.dirty_eviction);
        check_field("load_hit_count", want.load_hit_count, out_data.load_hit_count);
        check_field("load_miss_count", want.load_miss_count, out_data.load_miss_count);
        check_field("store_hit_count", want.store_hit_count, out_data.store_hit_count);
        check_field("store_miss_count", want.store_miss_count, out_data.store_miss_count);
        check_field("dirty_eviction_count", want.dirty_eviction_count,
                    out_data.dirty_eviction_count);
        checked_n++;
      end
    end
  end

  // Address extremes, fills, hits, aging and dirty eviction in one set
  task automatic test_directed_corners();
    idle_pct  = 0;
    stall_pct = 0;
    // lowest and highest address, then a same-block hit at each end
    send_access(32'h0000_0000, 1'b0);
    send_access(32'hFFFF_FFFF, 1'b1);
    send_access(32'h0000_003F, 1'b0);
    send_access(32'hFFFF_FFC0, 1'b0);
    // same set as address zero, different tag: next free way
    send_access(32'h8000_0000, 1'b1);
    // fill set 5 to the last way, stores on even tags
    for (int t = 1; t <= NUM_WAYS; t++)
      send_access(line_addr(TAG_W'(t), 8'd5, 6'd0), (t % 2) == 0);
    // load hit, then a store hit that dirties a clean line
    send_access(line_addr(18'd3, 8'd5, 6'h11), 1'b0);
    send_access(line_addr(18'd1, 8'd5, 6'h00), 1'b1);
    // miss on a full set: ages the set until a way reaches the top
    send_access(line_addr(18'd9, 8'd5, 6'h00), 1'b0);
    // miss where a way already sits at the top, so no aging
    send_access(line_addr(18'd10, 8'd5, 6'h00), 1'b1);
    send_access(line_addr(18'd9, 8'd5, 6'h3F), 1'b1);
    send_access(line_addr(18'd11, 8'd5, 6'h00), 1'b0);
    // an evicted tag returns as a miss
    send_access(line_addr(18'd2, 8'd5, 6'h00), 1'b0);
    send_access(line_addr('1, 8'd5, 6'h00), 1'b1);
  endtask

  // Mostly hot sets with a small tag pool, some fully random addresses
  task automatic test_random_traffic(input int n, input int idle, input int stall);
    logic [IDX_W-1:0] hot_set [4];
    logic [TAG_W-1:0] tag_pool [16];
    logic [31:0]      addr;
    int               pool_n;
    int               pick_a;
    int               pick_b;
    idle_pct  = idle;
    stall_pct = stall;
    pool_n    = $urandom_range(16, 9);
    foreach (hot_set[k]) hot_set[k] = IDX_W'($urandom_range(NUM_SETS - 1));
    foreach (tag_pool[k]) tag_pool[k] = TAG_W'($urandom);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 15) begin
        addr = $urandom;
      end else begin
        // skew toward low pool entries so some lines stay hot while others age out
        pick_a = $urandom_range(pool_n - 1);
        pick_b = $urandom_range(pool_n - 1);
        if (pick_b < pick_a) pick_a = pick_b;
        addr = line_addr(tag_pool[pick_a], hot_set[$urandom_range(3)], OFS_W'($urandom));
      end
      send_access(addr, $urandom_range(99) < 40);
    end
  endtask

  // Hold the result side for a long stretch while accesses keep coming
  task automatic test_output_hold();
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = HOLD_CYCLES;
    for (int i = 0; i < 64; i++)
      send_access(line_addr(TAG_W'(i % 12), IDX_W'(i % 3), OFS_W'($urandom)), (i % 2) == 1);
  endtask

  initial begin
    clear_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_corners();
    wait_drain();
    test_random_traffic(PHASE_ITEMS, 0, 0);
    wait_drain();
    test_random_traffic(PHASE_ITEMS, 76, 0);
    wait_drain();
    test_random_traffic(PHASE_ITEMS, 0, 76);
    wait_drain();
    test_random_traffic(PHASE_ITEMS, 36, 36);
    wait_drain();
    test_output_hold();
    wait_drain();
    stall_pct = 0;
    repeat (20) @(posedge clk);

    $display("%0d accesses, %0d results checked: %0d hits, %0d evictions, %0d dirty",
             accepted_n, checked_n, load_hits_n + store_hits_n, evict_n, dirty_evicts_n);
    $display("hot-set and random traffic under four idle/stall mixes and a %0d-cycle hold",
             HOLD_CYCLES);
    if (mismatch_n == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatch_n);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
